FILE: src/imuoc_pkg.sv
`default_nettype none
// shared constants, types and codes of the imu offset calibrator
package imuoc_pkg;

  // sample and axis geometry
  localparam int SAMPLE_W = 16;
  localparam int NUM_AXES = 6;
  localparam int AXIS_W   = $clog2(NUM_AXES);

  // longest averaging window supported
  localparam int MAX_WINDOW = 4096;

  // configuration register widths
  localparam int WLEN_W     = 13;
  localparam int DISC_W     = 10;
  localparam int DZ_W       = 8;
  localparam int GRAV_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // datapath widths
  localparam int DISC_MAX = 2**DISC_W - 1;
  localparam int IDX_W    = $clog2(MAX_WINDOW + DISC_MAX + 1);
  localparam int LEN_W    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W    = SAMPLE_W + IDX_W;
  localparam int DIVD_W   = SUM_W + 1;
  localparam int DIVS_W   = (LEN_W > DZ_W + 1) ? LEN_W : DZ_W + 1;
  localparam int DCNT_W   = $clog2(DIVD_W);
  localparam int N_W      = DIVD_W + 1;
  localparam int RCNT_W   = $clog2(NUM_AXES + 1);
  localparam int OUT_BITS = NUM_AXES * SAMPLE_W + 1;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // axis slots
  localparam logic [AXIS_W-1:0] AXIS_AX   = AXIS_W'(0);
  localparam logic [AXIS_W-1:0] AXIS_AY   = AXIS_W'(1);
  localparam logic [AXIS_W-1:0] AXIS_AZ   = AXIS_W'(2);
  localparam logic [AXIS_W-1:0] AXIS_GX   = AXIS_W'(3);
  localparam logic [AXIS_W-1:0] AXIS_GY   = AXIS_W'(4);
  localparam logic [AXIS_W-1:0] AXIS_GZ   = AXIS_W'(5);
  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  // register reset values
  localparam logic [WLEN_W-1:0] WLEN_RST = WLEN_W'(1000);
  localparam logic [DISC_W-1:0] DISC_RST = DISC_W'(101);
  localparam logic [DZ_W-1:0]   ADZ_RST  = DZ_W'(8);
  localparam logic [DZ_W-1:0]   GDZ_RST  = DZ_W'(1);
  localparam logic [GRAV_W-1:0] GRAV_RST = GRAV_W'(16384);

  // first-window divisors
  localparam int ACC_INIT_DIV = 8;
  localparam int GYR_INIT_DIV = 4;

  // offset saturation limits
  localparam logic signed [SAMPLE_W-1:0] OFF_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] OFF_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH,
    CFG_DISCARD_COUNT,
    CFG_ACCEL_DEADZONE,
    CFG_GYRO_DEADZONE,
    CFG_GRAVITY_REFERENCE
  } cfg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [WLEN_W-1:0] window_length;
    logic [DISC_W-1:0] discard_count;
    logic [DZ_W-1:0]   accel_deadzone;
    logic [DZ_W-1:0]   gyro_deadzone;
    logic [GRAV_W-1:0] gravity_reference;
  } cfg_t;

  // classified item as queued for the back end
  typedef struct packed {
    logic                       restart;
    sample_t [NUM_AXES-1:0]     axis;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    PH_INIT,
    PH_REFINE,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MEAN,
    BK_MEAN_WAIT,
    BK_CHECK,
    BK_STEP_WAIT,
    BK_FINISH,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

FILE: src/imuoc_in_if.sv
`default_nettype none
// input channel: valid/ready handshake carrying one six-axis item
interface imuoc_in_if import imuoc_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    op;
  sample_t accel_x;
  sample_t accel_y;
  sample_t accel_z;
  sample_t gyro_x;
  sample_t gyro_y;
  sample_t gyro_z;

  modport source (output valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  input ready);
  modport sink (input valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                output ready);
endinterface
`default_nettype wire

FILE: src/imuoc_out_if.sv
`default_nettype none
// result channel: valid/ready handshake carrying six offsets and the done flag
interface imuoc_out_if import imuoc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t accel_x_offset;
  sample_t accel_y_offset;
  sample_t accel_z_offset;
  sample_t gyro_x_offset;
  sample_t gyro_y_offset;
  sample_t gyro_z_offset;
  logic    calibrated;

  modport source (output valid, accel_x_offset, accel_y_offset, accel_z_offset,
                  gyro_x_offset, gyro_y_offset, gyro_z_offset, calibrated,
                  input ready);
  modport sink (input valid, accel_x_offset, accel_y_offset, accel_z_offset,
                gyro_x_offset, gyro_y_offset, gyro_z_offset, calibrated,
                output ready);
endinterface
`default_nettype wire

FILE: src/imu_offset_calibrator.sv
`default_nettype none
// imu offset calibrator top level: register file, front end, back end, divider
//
// in_ch takes six-axis items (op 0 = sample, accumulated as received,
// op 1 = restart); out_ch gives six 16-bit offsets and a calibrated flag.
// Items are accepted into a two-entry queue, so in_ch keeps accepting while
// a result waits in the output register for out_ch.ready.
// A sample that does not close a window is handled in BK_IDLE of the back end.
// A window end runs each axis mean through the one shared serial divider.
// The first window then scales by a shift; a later window gives each axis
// outside its deadzone a second division for its offset step.
// A restart gives its all-zero result via BK_EMIT and the result register.
// Once all axes are inside their deadzones, samples give no result until
// a restart. A stalled result holds the back end in place, the queue then
// fills and in_ch.ready drops. Synchronous reset loads the register
// defaults, clears sums, offsets and queue, and needs no clearing pass.
// cfg_we writes register cfg_index with cfg_data. The user must write only
// while the block is idle; the block itself has no guard for it.
module imu_offset_calibrator import imuoc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  imuoc_in_if.sink              in_ch,
  imuoc_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg_r;
  queue_head_t head;
  logic        pop;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length     <= WLEN_RST;
      cfg_r.discard_count     <= DISC_RST;
      cfg_r.accel_deadzone    <= ADZ_RST;
      cfg_r.gyro_deadzone     <= GDZ_RST;
      cfg_r.gravity_reference <= GRAV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH:     cfg_r.window_length     <= cfg_data[WLEN_W-1:0];
        CFG_DISCARD_COUNT:     cfg_r.discard_count     <= cfg_data[DISC_W-1:0];
        CFG_ACCEL_DEADZONE:    cfg_r.accel_deadzone    <= cfg_data[DZ_W-1:0];
        CFG_GYRO_DEADZONE:     cfg_r.gyro_deadzone     <= cfg_data[DZ_W-1:0];
        CFG_GRAVITY_REFERENCE: cfg_r.gravity_reference <= cfg_data[GRAV_W-1:0];
        default: ;
      endcase
    end
  end

  // item intake and queue
  imuoc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  // calibration sequencer and result register
  imuoc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .head    (head),
    .pop     (pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

  // shared divider
  imuoc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
`default_nettype wire

FILE: src/imuoc_div.sv
`default_nettype none
// shared restoring divider, one quotient bit per cycle
module imuoc_div import imuoc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dsr_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;

  // one trial subtraction
  always_comb begin
    trial = {rem_r, quo_r[DIVD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = trial >= {1'b0, dsr_r};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

FILE: src/imuoc_front.sv
`default_nettype none
// front end: accepts items, classifies restart versus sample, queues them
module imuoc_front import imuoc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  imuoc_in_if.sink    in_ch,
  input  logic        pop,
  output queue_head_t head
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  cmd_t              cmd_in;
  logic              push;

  // classify the incoming item
  always_comb begin
    cmd_in.restart       = in_ch.op;
    cmd_in.axis[AXIS_AX] = in_ch.accel_x;
    cmd_in.axis[AXIS_AY] = in_ch.accel_y;
    cmd_in.axis[AXIS_AZ] = in_ch.accel_z;
    cmd_in.axis[AXIS_GX] = in_ch.gyro_x;
    cmd_in.axis[AXIS_GY] = in_ch.gyro_y;
    cmd_in.axis[AXIS_GZ] = in_ch.gyro_z;
  end

  assign in_ch.ready = cnt_r != QCNT_W'(QDEPTH);
  assign push        = in_ch.valid && in_ch.ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign head.valid = cnt_r != '0;
  assign head.cmd   = mem_r[rd_ptr_r];

endmodule
`default_nettype wire

FILE: src/imuoc_back.sv
`default_nettype none
// back end: window accumulation, per-axis mean and offset update, result register
module imuoc_back import imuoc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  queue_head_t head,
  output logic        pop,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  imuoc_out_if.source out_ch
);

  localparam int S_W = N_W + 1;
  localparam logic signed [S_W-1:0] SAT_HI = S_W'(OFF_MAX);
  localparam logic signed [S_W-1:0] SAT_LO = S_W'(OFF_MIN);

  back_state_t              state_r;
  back_state_t              state_nxt;
  phase_t                   phase_r;
  logic signed [SUM_W-1:0]  sums_r    [NUM_AXES];
  logic signed [SAMPLE_W-1:0] offsets_r [NUM_AXES];
  logic [IDX_W-1:0]         idx_r;
  logic [AXIS_W-1:0]        axis_r;
  logic [RCNT_W-1:0]        rdy_cnt_r;
  logic                     cal_r;
  logic signed [N_W-1:0]    n_r;
  logic                     out_valid_r;
  logic signed [SAMPLE_W-1:0] out_off_r [NUM_AXES];
  logic                     out_cal_r;

  logic [LEN_W-1:0]         len_eff;
  logic [DZ_W-1:0]          adz_eff;
  logic [DZ_W-1:0]          tol;
  logic [DIVS_W-1:0]        k_sel;
  logic                     is_gyro;
  logic                     is_z;
  logic                     last_axis;
  logic [IDX_W:0]           idx_inc;
  logic [IDX_W:0]           win_limit;
  logic                     window_end;
  logic                     in_window;
  logic signed [SUM_W-1:0]  sum_sel;
  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_mag;
  logic [N_W-1:0]           grav_sel;
  logic [N_W-1:0]           q_n;
  logic signed [N_W-1:0]    n_calc;
  logic                     n_neg;
  logic [DIVD_W-1:0]        n_mag;
  logic                     skip_step;
  logic                     need_div;
  logic [DIVD_W-1:0]        q_step;
  logic signed [S_W-1:0]    base_s;
  logic signed [S_W-1:0]    q2_s;
  logic signed [S_W-1:0]    upd;
  logic signed [SAMPLE_W-1:0] offset_new;
  logic                     all_ready;
  logic                     out_load;
  logic                     take_sample;

  // effective register values
  always_comb begin
    if (cfg.window_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(cfg.window_length) > 32'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(cfg.window_length);
    end
    adz_eff = (cfg.accel_deadzone == '0) ? DZ_W'(1) : cfg.accel_deadzone;
  end

  // axis-dependent tolerance and divisor
  always_comb begin
    is_gyro   = axis_r >= AXIS_GX;
    is_z      = axis_r == AXIS_AZ;
    last_axis = axis_r == AXIS_LAST;
    tol       = is_gyro ? cfg.gyro_deadzone : adz_eff;
    k_sel     = is_gyro ? DIVS_W'(cfg.gyro_deadzone) + 1'b1 : DIVS_W'(adz_eff);
  end

  // window position
  always_comb begin
    idx_inc     = {1'b0, idx_r} + (IDX_W + 1)'(1);
    win_limit   = (IDX_W + 1)'(cfg.discard_count) + (IDX_W + 1)'(len_eff);
    window_end  = idx_inc >= win_limit;
    in_window   = idx_r >= IDX_W'(cfg.discard_count);
    take_sample = (state_r == BK_IDLE) && head.valid && !head.cmd.restart
                  && (phase_r != PH_DONE);
  end

  // mean magnitude and signed deviation of the current axis
  always_comb begin
    sum_sel  = sums_r[axis_r];
    sum_neg  = sum_sel[SUM_W-1];
    sum_mag  = sum_neg ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    grav_sel = is_z ? N_W'(cfg.gravity_reference) : '0;
    q_n      = N_W'(div_rsp.quotient);
    n_calc   = sum_neg ? signed'(grav_sel + q_n) : signed'(grav_sel - q_n);
    n_neg    = n_r[N_W-1];
    n_mag    = n_neg ? DIVD_W'(-n_r) : DIVD_W'(n_r);
    skip_step = (phase_r == PH_REFINE) && (n_mag <= DIVD_W'(tol));
    need_div  = (phase_r == PH_REFINE) && !skip_step;
  end

  // offset step with saturation; first window scales by a power of two
  always_comb begin
    if (phase_r == PH_INIT) begin
      q_step = is_gyro ? n_mag / DIVD_W'(GYR_INIT_DIV) : n_mag / DIVD_W'(ACC_INIT_DIV);
    end else begin
      q_step = div_rsp.quotient;
    end
    base_s = (phase_r == PH_INIT) ? '0 : S_W'(offsets_r[axis_r]);
    q2_s   = signed'(S_W'(q_step));
    upd    = n_neg ? base_s - q2_s : base_s + q2_s;
    if (upd > SAT_HI) begin
      offset_new = OFF_MAX;
    end else if (upd < SAT_LO) begin
      offset_new = OFF_MIN;
    end else begin
      offset_new = upd[SAMPLE_W-1:0];
    end
    all_ready = rdy_cnt_r == RCNT_W'(NUM_AXES);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          if (head.cmd.restart) begin
            state_nxt = BK_EMIT;
          end else if (phase_r != PH_DONE && window_end) begin
            state_nxt = BK_MEAN;
          end
        end
      end
      BK_MEAN: state_nxt = BK_MEAN_WAIT;
      BK_MEAN_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = BK_CHECK;
        end
      end
      BK_CHECK: begin
        if (need_div) begin
          state_nxt = BK_STEP_WAIT;
        end else if (last_axis) begin
          state_nxt = BK_FINISH;
        end else begin
          state_nxt = BK_MEAN;
        end
      end
      BK_STEP_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = last_axis ? BK_FINISH : BK_MEAN;
        end
      end
      BK_FINISH: state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (out_load) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop              = (state_r == BK_IDLE) && head.valid;
    out_load         = (state_r == BK_EMIT) && (!out_valid_r || out_ch.ready);
    div_req.start    = (state_r == BK_MEAN) || ((state_r == BK_CHECK) && need_div);
    div_req.dividend = (state_r == BK_MEAN) ? DIVD_W'(sum_mag) : n_mag;
    div_req.divisor  = (state_r == BK_MEAN) ? DIVS_W'(len_eff) : k_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_INIT;
      idx_r     <= '0;
      axis_r    <= '0;
      rdy_cnt_r <= '0;
      cal_r     <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sums_r[i]    <= '0;
        offsets_r[i] <= '0;
      end
    end else begin
      case (state_r)
        BK_IDLE: begin
          if (pop && head.cmd.restart) begin
            phase_r <= PH_INIT;
            idx_r   <= '0;
            cal_r   <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
              sums_r[i]    <= '0;
              offsets_r[i] <= '0;
            end
          end else if (take_sample) begin
            if (in_window) begin
              for (int i = 0; i < NUM_AXES; i++) begin
                sums_r[i] <= sums_r[i] + SUM_W'(head.cmd.axis[i]);
              end
            end
            if (window_end) begin
              idx_r     <= '0;
              axis_r    <= '0;
              rdy_cnt_r <= '0;
            end else begin
              idx_r <= idx_inc[IDX_W-1:0];
            end
          end
        end
        BK_CHECK: begin
          if (skip_step) begin
            rdy_cnt_r <= rdy_cnt_r + 1'b1;
            axis_r    <= axis_r + 1'b1;
          end else if (!need_div) begin
            offsets_r[axis_r] <= offset_new;
            axis_r            <= axis_r + 1'b1;
          end
        end
        BK_STEP_WAIT: begin
          if (div_rsp.done) begin
            offsets_r[axis_r] <= offset_new;
            axis_r            <= axis_r + 1'b1;
          end
        end
        BK_FINISH: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            sums_r[i] <= '0;
          end
          if (phase_r == PH_INIT) begin
            phase_r <= PH_REFINE;
            cal_r   <= 1'b0;
          end else begin
            phase_r <= all_ready ? PH_DONE : PH_REFINE;
            cal_r   <= all_ready;
          end
        end
        default: ;
      endcase
    end
  end

  // window deviation capture
  always_ff @(posedge clk) begin
    if (state_r == BK_MEAN_WAIT && div_rsp.done) begin
      n_r <= n_calc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        out_off_r[i] <= offsets_r[i];
      end
      out_cal_r <= cal_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accel_x_offset = out_off_r[AXIS_AX];
  assign out_ch.accel_y_offset = out_off_r[AXIS_AY];
  assign out_ch.accel_z_offset = out_off_r[AXIS_AZ];
  assign out_ch.gyro_x_offset  = out_off_r[AXIS_GX];
  assign out_ch.gyro_y_offset  = out_off_r[AXIS_GY];
  assign out_ch.gyro_z_offset  = out_off_r[AXIS_GZ];
  assign out_ch.calibrated     = out_cal_r;

endmodule
`default_nettype wire

FILE: src/imuoc_checker.sv
`default_nettype none
// port-level assertions for the imu offset calibrator and their bind
module imuoc_checker import imuoc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OUT_BITS-1:0] out_data
);

  // reset empties the queue and the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("reset did not clear queue and result register");

  // queue fills only through an accepted item
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("in ready dropped without an accepted item");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result payload changed while stalled");

endmodule

bind imu_offset_calibrator imuoc_checker u_imuoc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.accel_x_offset, out_ch.accel_y_offset, out_ch.accel_z_offset,
               out_ch.gyro_x_offset, out_ch.gyro_y_offset, out_ch.gyro_z_offset,
               out_ch.calibrated})
);
`default_nettype wire
